FILE: hdl/shb_pkg.sv
package shb_pkg;

  localparam int KEY_W           = 64;
  localparam int HASH_W          = 32;
  localparam int IDX_W           = 16;
  localparam int CFG_W           = 32;
  localparam int BC_W            = 17;
  localparam int BC_LIMIT        = 131071;
  localparam int BC_RESET        = 1024;
  localparam int MAX_BUCKETS_DEF = 65536;
  localparam int KEY_BYTES       = 8;
  localparam int CFG_IDX_W       = 1;

  localparam int MIX_SHL   = 10;
  localparam int MIX_SHR   = 6;
  localparam int FIN_SHL_A = 3;
  localparam int FIN_SHR   = 11;
  localparam int FIN_SHL_B = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_SEED    = 1'b0,
    REG_BUCKET_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              vld;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
  } mix_t;

  typedef struct packed {
    logic              vld;
    logic [HASH_W-1:0] hash;
  } pipe_t;

endpackage

FILE: hdl/shb_mix_cell.sv
module shb_mix_cell
  import shb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  mix_t mix_in,
  output mix_t mix_out
);

  logic              vld_r;
  logic [KEY_W-1:0]  key_r;
  logic [HASH_W-1:0] hash_r;
  logic [KEY_W-1:0]  key_nxt;
  logic [HASH_W-1:0] hash_nxt;
  logic [HASH_W-1:0] h_add;
  logic [HASH_W-1:0] h_shl;

  // one byte round, key drains a byte per cell
  always_comb begin
    h_add    = mix_in.hash + HASH_W'(mix_in.key[7:0]);
    h_shl    = h_add + (h_add << MIX_SHL);
    hash_nxt = h_shl ^ (h_shl >> MIX_SHR);
    key_nxt  = mix_in.key >> 8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= mix_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    hash_r <= hash_nxt;
  end

  assign mix_out.vld  = vld_r;
  assign mix_out.key  = key_r;
  assign mix_out.hash = hash_r;

endmodule

FILE: hdl/shb_fin_cell.sv
module shb_fin_cell
  import shb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  pipe_t fin_in,
  output pipe_t fin_out
);

  logic              vld_r;
  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_nxt;
  logic [HASH_W-1:0] h1;
  logic [HASH_W-1:0] h2;

  // final avalanche
  always_comb begin
    h1       = fin_in.hash + (fin_in.hash << FIN_SHL_A);
    h2       = h1 ^ (h1 >> FIN_SHR);
    hash_nxt = h2 + (h2 << FIN_SHL_B);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= fin_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
  end

  assign fin_out.vld  = vld_r;
  assign fin_out.hash = hash_r;

endmodule

FILE: hdl/shb_div_cell.sv
module shb_div_cell
  import shb_pkg::*;
#(
  parameter int DIV_W = BC_W
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DIV_W-1:0] divisor,
  input  pipe_t            div_in,
  input  logic [DIV_W-1:0] rem_in,
  input  logic             bit_in,
  output pipe_t            div_out,
  output logic [DIV_W-1:0] rem_out
);

  logic              vld_r;
  logic [HASH_W-1:0] hash_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  rem_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    dvs_ext;

  // one restoring step of the remainder
  always_comb begin
    trial   = {rem_in, bit_in};
    dvs_ext = {1'b0, divisor};
    if (trial >= dvs_ext) begin
      rem_nxt = DIV_W'(trial - dvs_ext);
    end else begin
      rem_nxt = DIV_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= div_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= div_in.hash;
    rem_r  <= rem_nxt;
  end

  assign div_out.vld  = vld_r;
  assign div_out.hash = hash_r;
  assign rem_out      = rem_r;

endmodule

FILE: hdl/seeded_hash_bucket_index_unit.sv
// channel   ports                                   transfer
// input     start, busy, in_key_value               start high, busy low
// result    out_valid, out_hash_value,              out_valid high, one cycle
//           out_bucket_index
// config    cfg_we, cfg_index, cfg_data             cfg_we high
//
// one key per cycle
// pipeline: 8 byte-mix cells, one avalanche cell, 32 remainder cells
// busy is high only while rst_n is low; reset empties the chain
// the receiver cannot stall; results leave on the fixed schedule
module seeded_hash_bucket_index_unit
  import shb_pkg::*;
#(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [KEY_W-1:0]     in_key_value,
  output logic                 out_valid,
  output logic [HASH_W-1:0]    out_hash_value,
  output logic [IDX_W-1:0]     out_bucket_index,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DIV_MAX    = (MAX_BUCKETS > BC_LIMIT) ? BC_LIMIT : MAX_BUCKETS;
  localparam int DIV_W      = $clog2(DIV_MAX + 1);
  localparam int DIV_RESET  = (BC_RESET > MAX_BUCKETS) ? MAX_BUCKETS : BC_RESET;
  localparam int DIV_STAGES = HASH_W;
  localparam int LATENCY    = KEY_BYTES + 1 + DIV_STAGES;

  logic [HASH_W-1:0] seed_r;
  logic [DIV_W-1:0]  div_r;
  logic [DIV_W-1:0]  div_nxt;
  logic [31:0]       bc_ext;

  mix_t              mix_q [0:KEY_BYTES];
  pipe_t             fin_in;
  pipe_t             div_q [0:DIV_STAGES];
  logic [DIV_W-1:0]  rem_q [0:DIV_STAGES];

  assign busy = !rst_n;

  // zero reads as one, above the limit saturates
  always_comb begin
    bc_ext = 32'(cfg_data[BC_W-1:0]);
    if (bc_ext == 32'd0) begin
      div_nxt = DIV_W'(1);
    end else if (bc_ext > 32'(MAX_BUCKETS)) begin
      div_nxt = DIV_W'(DIV_MAX);
    end else begin
      div_nxt = DIV_W'(bc_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      div_r  <= DIV_W'(DIV_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HASH_SEED:    seed_r <= cfg_data[HASH_W-1:0];
        REG_BUCKET_COUNT: div_r  <= div_nxt;
      endcase
    end
  end

  assign mix_q[0].vld  = start && !busy;
  assign mix_q[0].key  = in_key_value;
  assign mix_q[0].hash = seed_r + HASH_W'(KEY_BYTES);

  for (genvar g = 0; g < KEY_BYTES; g++) begin : g_mix
    shb_mix_cell u_mix (
      .clk     (clk),
      .rst_n   (rst_n),
      .mix_in  (mix_q[g]),
      .mix_out (mix_q[g+1])
    );
  end

  assign fin_in.vld  = mix_q[KEY_BYTES].vld;
  assign fin_in.hash = mix_q[KEY_BYTES].hash;

  shb_fin_cell u_fin (
    .clk     (clk),
    .rst_n   (rst_n),
    .fin_in  (fin_in),
    .fin_out (div_q[0])
  );

  assign rem_q[0] = '0;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    shb_div_cell #(
      .DIV_W (DIV_W)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .divisor (div_r),
      .div_in  (div_q[g]),
      .rem_in  (rem_q[g]),
      .bit_in  (div_q[g].hash[DIV_STAGES-1-g]),
      .div_out (div_q[g+1]),
      .rem_out (rem_q[g+1])
    );
  end

  assign out_valid        = div_q[DIV_STAGES].vld;
  assign out_hash_value   = div_q[DIV_STAGES].hash;
  assign out_bucket_index = IDX_W'(rem_q[DIV_STAGES]);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == ($past(start && !busy, LATENCY) === 1'b1))
    else $error("result strobe out of step with accepted keys");

  a_hash_carry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hash_value == $past(div_q[0].hash, DIV_STAGES))
    else $error("hash altered in the remainder chain");

  a_key_drained: assert property (@(posedge clk) disable iff (!rst_n)
    mix_q[KEY_BYTES].vld |-> mix_q[KEY_BYTES].key == '0)
    else $error("key bytes left after the mix chain");

endmodule

FILE: dv/tb_top.sv
module tb_top
  import shb_pkg::*;
();

  localparam int LATENCY     = 41;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 26;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 65;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [IDX_W-1:0]  bidx;
  } bucket_result_t;

  class hash_scoreboard;
    logic [HASH_W-1:0] seed;
    logic [BC_W-1:0]   buckets;
    bucket_result_t    pending[$];
    int                n_checked;
    int                n_errors;

    function new();
      seed      = '0;
      buckets   = BC_W'(BC_RESET);
      n_checked = 0;
      n_errors  = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
      if (idx == REG_HASH_SEED) begin
        seed = data[HASH_W-1:0];
      end else if (idx == REG_BUCKET_COUNT) begin
        buckets = data[BC_W-1:0];
      end
    endfunction

    function logic [HASH_W-1:0] oaat_hash(logic [KEY_W-1:0] k);
      logic [HASH_W-1:0] h;
      h = seed + HASH_W'(KEY_BYTES);
      for (int i = 0; i < KEY_BYTES; i++) begin
        h = h + HASH_W'(k[8*i +: 8]);
        h = h + (h << MIX_SHL);
        h = h ^ (h >> MIX_SHR);
      end
      h = h + (h << FIN_SHL_A);
      h = h ^ (h >> FIN_SHR);
      h = h + (h << FIN_SHL_B);
      return h;
    endfunction

    function void note_key(logic [KEY_W-1:0] k);
      bucket_result_t r;
      logic [31:0]    n;
      n = 32'(buckets);
      // zero acts as one, oversize saturates
      if (n == 0) n = 1;
      if (n > MAX_BUCKETS_DEF) n = MAX_BUCKETS_DEF;
      r.hash = oaat_hash(k);
      r.bidx = IDX_W'(32'(r.hash) % n);
      pending.push_back(r);
    endfunction

    function void check_result(logic [HASH_W-1:0] h, logic [IDX_W-1:0] ix);
      bucket_result_t e;
      if (pending.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch: unexpected result hash %08h index %0d", h, ix);
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (e.hash !== h || e.bidx !== ix) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch: expected hash %08h index %0d, got hash %08h index %0d",
                   e.hash, e.bidx, h, ix);
      end
    endfunction

    function void report_leftover();
      if (pending.size() != 0) begin
        $display("%0d expected results never arrived", pending.size());
        n_errors += pending.size();
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [KEY_W-1:0]     in_key_value;
  logic                 out_valid;
  logic [HASH_W-1:0]    out_hash_value;
  logic [IDX_W-1:0]     out_bucket_index;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  hash_scoreboard sb = new();
  int             stall_count = 0;
  int             n_keys = 0;
  int             n_settings = 0;
  bit             no_idle = 0;

  seeded_hash_bucket_index_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_key_value     (in_key_value),
    .out_valid        (out_valid),
    .out_hash_value   (out_hash_value),
    .out_bucket_index (out_bucket_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // monitor: input transfers, register writes, result transfers
  always @(posedge clk) begin
    if (cfg_we) begin
      sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
    end
    if (start && !busy) begin
      sb.note_key(in_key_value);
      n_keys++;
    end
    if (rst_n && out_valid) begin
      sb.check_result(out_hash_value, out_bucket_index);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(3))
      0: k = {$urandom, $urandom};
      1: begin
        k = KEY_W'($urandom_range(1000));
        if ($urandom_range(1)) k = -k;
      end
      2: k = KEY_W'($urandom_range(255)) << (8 * $urandom_range(7));
      default: k = ~(KEY_W'($urandom_range(255)) << (8 * $urandom_range(7)));
    endcase
    return k;
  endfunction

  task automatic idle_gap();
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      start        <= 1'b0;
      in_key_value <= {$urandom, $urandom};
      @(posedge clk);
    end
  endtask

  task automatic send_key(input logic [KEY_W-1:0] k);
    idle_gap();
    start        <= 1'b1;
    in_key_value <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // wait for the chain to empty, then write both registers
  task automatic set_regs(input logic [CFG_W-1:0] seed, input logic [CFG_W-1:0] bc_raw);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HASH_SEED;
    cfg_data  <= seed;
    @(posedge clk);
    cfg_index <= REG_BUCKET_COUNT;
    cfg_data  <= bc_raw;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [CFG_W-1:0] rand_buckets();
    logic [CFG_W-1:0] b;
    case ($urandom_range(4))
      0: b = $urandom_range(16);
      1: b = 1 << $urandom_range(16);
      2: b = $urandom_range(65536, 65530);
      default: b = $urandom_range(BC_LIMIT);
    endcase
    // upper bits are outside the register and must be dropped
    return {CFG_W'($urandom) & ~CFG_W'(BC_LIMIT)} | b;
  endfunction

  initial begin
    logic [KEY_W-1:0] edge_keys[8];
    edge_keys = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'h1, 64'h0102_0304_0506_0708,
                  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
    start        <= 1'b0;
    in_key_value <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_HASH_SEED;
    cfg_data     <= '0;
    rst_n        <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, key extremes
    foreach (edge_keys[i]) send_key(edge_keys[i]);

    // single bucket, top seed
    set_regs(32'hFFFF_FFFF, 32'd1);
    for (int i = 0; i < 4; i++) send_key(edge_keys[i]);
    // bucket count zero acts as one
    set_regs($urandom, 32'd0);
    for (int i = 0; i < 4; i++) send_key(edge_keys[i + 4]);
    // seed plus eight wraps to zero, largest legal count
    set_regs(32'hFFFF_FFF8, 32'd65536);
    for (int i = 0; i < 4; i++) send_key(edge_keys[2 * i]);
    // oversize counts saturate
    set_regs(32'h1234_5678, 32'd65537);
    send_key(64'hFFFF_FFFF_FFFF_FFFF);
    send_key(64'h8000_0000_0000_0000);
    set_regs(32'h0, 32'hFFFF_FFFF);
    send_key(64'h7FFF_FFFF_FFFF_FFFF);
    send_key(64'h0);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: set_regs(32'h0, 32'd65536);
        1: set_regs(32'hFFFF_FFFF, 32'd1);
        2: set_regs($urandom, 32'd2);
        default: set_regs($urandom, rand_buckets());
      endcase
      no_idle = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) send_key(rand_key());
    end
    no_idle = 1'b0;

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    sb.report_leftover();

    $display("%0d keys hashed under %0d register settings, %0d results checked",
             n_keys, n_settings, sb.n_checked);
    $display("%0d mismatches", sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
